>>> sv/serial_frame_receiver_crc16_assert.svh
// assertion macros for the serial frame receiver
// no dependencies; included by files that carry concurrent checks
`ifndef SERIAL_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SFR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sfr_pkg.sv
// shared types, constants and functions of the serial frame receiver
// no dependencies; used by every module of the block
`default_nettype none

package sfr_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int WIN_AW      = $clog2(FRAME_BYTES);
    localparam int WIN_DEPTH   = 1 << WIN_AW;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int IN_TDATA_W  = 8;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [FILL_W-1:0] FRAME_FULL = FILL_W'(FRAME_BYTES);
    localparam logic [FILL_W-1:0] FRAME_LAST = FILL_W'(FRAME_BYTES - 1);

    // byte positions inside a frame
    localparam logic [FILL_W-1:0] IDX_VERSION      = FILL_W'(2);
    localparam logic [FILL_W-1:0] IDX_TYPE         = FILL_W'(3);
    localparam logic [FILL_W-1:0] IDX_SEQ          = FILL_W'(4);
    localparam logic [FILL_W-1:0] IDX_LEN          = FILL_W'(5);
    localparam logic [FILL_W-1:0] IDX_PAYLOAD      = FILL_W'(6);
    localparam logic [FILL_W-1:0] IDX_PAYLOAD_LAST = FILL_W'(20);
    localparam logic [FILL_W-1:0] CRC_SPAN         = FILL_W'(FRAME_BYTES - 2);
    localparam logic [FILL_W-1:0] IDX_CRC_LO       = FILL_W'(FRAME_BYTES - 2);
    localparam logic [FILL_W-1:0] IDX_CRC_HI       = FILL_W'(FRAME_BYTES - 1);
    localparam logic [FILL_W-1:0] FIRST_PAIR_END   = FILL_W'(2);

    localparam int PAYLOAD_KEPT_W = 15 * BYTE_W;

    localparam logic [BYTE_W-1:0] SYNC0       = 8'h44;
    localparam logic [BYTE_W-1:0] SYNC1       = 8'h54;
    localparam logic [BYTE_W-1:0] HDR_VERSION = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_TYPE    = 8'h20;
    localparam logic [BYTE_W-1:0] HDR_LEN     = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam int OUT_FIELDS_W = 185;
    localparam int TDATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int TDATA_PAD    = TDATA_W - OUT_FIELDS_W;
    localparam int TUSER_W      = 2;

    typedef enum logic [TUSER_W-1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_ACCEPT  = 2'd1,
        STATUS_CRC_ERR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_RESOLVE,
        ENG_EMIT
    } eng_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_sync0;
        logic              is_sync1;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } queue_out_t;

    typedef struct packed {
        logic [TDATA_PAD-1:0] pad;
        logic [COUNT_W-1:0]   crc_error_total;
        logic [COUNT_W-1:0]   drop_total;
        logic                 safe_flag;
        logic [7:0]           remote_sequence;
        logic [7:0]           event_code;
        logic [31:0]          remote_age;
        logic [15:0]          button_bits;
        logic signed [15:0]   heading;
        logic signed [15:0]   pos_y;
        logic signed [15:0]   pos_x;
        logic [7:0]           frame_seq;
    } out_data_t;

    typedef struct packed {
        status_t   status;
        out_data_t data;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [FILL_W-1:0] n);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + (COUNT_W + 1)'(n);
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/sfr_front.sv
// input side: takes received bytes, marks sync bytes, queues them for the engine
// depends on sfr_pkg
`default_nettype none

module sfr_front #(
    parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // rx_byte
    input  logic                            q_pop,
    output sfr_pkg::queue_out_t             q_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sfr_pkg::q_entry_t q_entry_reg [QUEUE_DEPTH];
    sfr_pkg::q_entry_t entry_in;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign entry_in.rx_byte  = s_axis_tdata;
    assign entry_in.is_sync0 = (s_axis_tdata == sfr_pkg::SYNC0);
    assign entry_in.is_sync1 = (s_axis_tdata == sfr_pkg::SYNC1);

    assign s_axis_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;

    assign q_out.valid = (count_reg != '0);
    assign q_out.entry = q_entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/sfr_engine.sv
// frame engine: byte window memory, resync, header and crc pass, counters
// depends on sfr_pkg
`default_nettype none

module sfr_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sfr_pkg::queue_out_t          q_in,
    output logic                         q_pop,
    input  logic                         out_free,
    output logic                         out_wr,
    output sfr_pkg::result_t             out_res,
    output logic [sfr_pkg::FILL_W-1:0]   fill_level
);

    localparam int FILL_W = sfr_pkg::FILL_W;
    localparam int WIN_AW = sfr_pkg::WIN_AW;
    localparam int BYTE_W = sfr_pkg::BYTE_W;
    localparam int CNT_W  = sfr_pkg::COUNT_W;
    localparam int PAY_W  = sfr_pkg::PAYLOAD_KEPT_W;

    logic [BYTE_W-1:0] win_mem [sfr_pkg::WIN_DEPTH];

    sfr_pkg::eng_state_t state_reg, state_next;
    sfr_pkg::status_t    status_reg, status_next;

    logic [WIN_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              held_d_reg, held_d_next;
    logic [CNT_W-1:0]  drop_reg, drop_next;
    logic [CNT_W-1:0]  crc_err_reg, crc_err_next;
    logic              rd_vld_reg, rd_vld_next;

    logic [FILL_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       crc_rx_reg, crc_rx_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic              prev_d_reg, prev_d_next;
    logic              found_reg, found_next;
    logic [FILL_W-1:0] found_pos_reg, found_pos_next;
    logic              last_d_reg, last_d_next;
    logic [7:0]        seq_reg, seq_next;
    logic [PAY_W-1:0]  payload_reg, payload_next;
    logic [BYTE_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [WIN_AW-1:0] mem_waddr;
    logic [WIN_AW-1:0] rd_addr;
    logic [FILL_W-1:0] drop_add;
    logic              start_scan;
    logic              scan_done;
    logic              rd_is_d;
    logic              rd_is_t;
    logic              hdr_bad;
    logic              frame_good;

    assign start_scan = q_in.valid && (fill_reg == sfr_pkg::FRAME_LAST);
    assign scan_done  = rd_vld_reg && (rd_idx_reg == sfr_pkg::FRAME_LAST);
    assign rd_is_d    = (rd_data_reg == sfr_pkg::SYNC0);
    assign rd_is_t    = (rd_data_reg == sfr_pkg::SYNC1);
    assign hdr_bad    = ((rd_idx_reg == sfr_pkg::IDX_VERSION) && (rd_data_reg != sfr_pkg::HDR_VERSION))
                     || ((rd_idx_reg == sfr_pkg::IDX_TYPE) && (rd_data_reg != sfr_pkg::HDR_TYPE))
                     || ((rd_idx_reg == sfr_pkg::IDX_LEN) && (rd_data_reg != sfr_pkg::HDR_LEN));
    assign frame_good = hdr_ok_reg && (crc_reg == crc_rx_reg);
    assign rd_addr    = head_reg + WIN_AW'(scan_cnt_reg);
    assign mem_waddr  = head_reg + WIN_AW'(fill_reg);
    assign fill_level = fill_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfr_pkg::ENG_IDLE: begin
                if (q_in.valid) begin
                    state_next = start_scan ? sfr_pkg::ENG_SCAN : sfr_pkg::ENG_EMIT;
                end
            end
            sfr_pkg::ENG_SCAN: begin
                if (scan_done) begin
                    state_next = sfr_pkg::ENG_RESOLVE;
                end
            end
            sfr_pkg::ENG_RESOLVE: begin
                state_next = sfr_pkg::ENG_EMIT;
            end
            sfr_pkg::ENG_EMIT: begin
                if (out_free) begin
                    state_next = sfr_pkg::ENG_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        q_pop          = 1'b0;
        out_wr         = 1'b0;
        mem_we         = 1'b0;
        drop_add       = '0;
        status_next    = status_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        held_d_next    = held_d_reg;
        crc_err_next   = crc_err_reg;
        rd_vld_next    = 1'b0;
        scan_cnt_next  = scan_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        crc_next       = crc_reg;
        crc_rx_next    = crc_rx_reg;
        hdr_ok_next    = hdr_ok_reg;
        prev_d_next    = prev_d_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        last_d_next    = last_d_reg;
        seq_next       = seq_reg;
        payload_next   = payload_reg;

        unique case (state_reg)
            sfr_pkg::ENG_IDLE: begin
                if (q_in.valid) begin
                    q_pop       = 1'b1;
                    mem_we      = 1'b1;
                    status_next = sfr_pkg::STATUS_NONE;
                    priority if (fill_reg == '0) begin
                        fill_next   = FILL_W'(1);
                        held_d_next = q_in.entry.is_sync0;
                    end else if (fill_reg == FILL_W'(1)) begin
                        if (held_d_reg && q_in.entry.is_sync1) begin
                            fill_next = FILL_W'(2);
                        end else if (q_in.entry.is_sync0) begin
                            // lone sync start kept as the new first byte
                            drop_add    = FILL_W'(1);
                            head_next   = head_reg + WIN_AW'(1);
                            fill_next   = FILL_W'(1);
                            held_d_next = 1'b1;
                        end else begin
                            drop_add  = FILL_W'(2);
                            fill_next = '0;
                        end
                    end else begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (start_scan) begin
                        scan_cnt_next = '0;
                        crc_next      = sfr_pkg::CRC_INIT;
                        hdr_ok_next   = 1'b1;
                        prev_d_next   = 1'b0;
                        found_next    = 1'b0;
                        last_d_next   = 1'b0;
                    end
                end
            end
            sfr_pkg::ENG_SCAN: begin
                if (scan_cnt_reg != sfr_pkg::FRAME_FULL) begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_cnt_reg;
                    scan_cnt_next = scan_cnt_reg + FILL_W'(1);
                end
                if (rd_vld_reg) begin
                    if (rd_idx_reg < sfr_pkg::CRC_SPAN) begin
                        crc_next = sfr_pkg::crc16_byte(crc_reg, rd_data_reg);
                    end
                    if (hdr_bad) begin
                        hdr_ok_next = 1'b0;
                    end
                    if (rd_idx_reg == sfr_pkg::IDX_SEQ) begin
                        seq_next = rd_data_reg;
                    end
                    if ((rd_idx_reg >= sfr_pkg::IDX_PAYLOAD)
                        && (rd_idx_reg <= sfr_pkg::IDX_PAYLOAD_LAST)) begin
                        payload_next = {rd_data_reg, payload_reg[PAY_W-1:BYTE_W]};
                    end
                    if (rd_idx_reg == sfr_pkg::IDX_CRC_LO) begin
                        crc_rx_next[7:0] = rd_data_reg;
                    end
                    if (rd_idx_reg == sfr_pkg::IDX_CRC_HI) begin
                        crc_rx_next[15:8] = rd_data_reg;
                    end
                    // first sync pair after the start byte
                    if ((rd_idx_reg >= sfr_pkg::FIRST_PAIR_END) && !found_reg
                        && prev_d_reg && rd_is_t) begin
                        found_next     = 1'b1;
                        found_pos_next = rd_idx_reg - FILL_W'(1);
                    end
                    prev_d_next = rd_is_d;
                    last_d_next = rd_is_d;
                end
            end
            sfr_pkg::ENG_RESOLVE: begin
                if (frame_good) begin
                    status_next = sfr_pkg::STATUS_ACCEPT;
                    fill_next   = '0;
                end else begin
                    status_next = hdr_ok_reg ? sfr_pkg::STATUS_CRC_ERR : sfr_pkg::STATUS_NONE;
                    if (hdr_ok_reg) begin
                        crc_err_next = sfr_pkg::sat_add(crc_err_reg, FILL_W'(1));
                    end
                    if (found_reg) begin
                        head_next = head_reg + WIN_AW'(found_pos_reg);
                        fill_next = sfr_pkg::FRAME_FULL - found_pos_reg;
                        drop_add  = hdr_ok_reg ? (found_pos_reg - FILL_W'(1)) : found_pos_reg;
                    end else begin
                        head_next   = head_reg + WIN_AW'(sfr_pkg::FRAME_LAST);
                        fill_next   = FILL_W'(last_d_reg);
                        held_d_next = 1'b1;
                        drop_add    = hdr_ok_reg ? (sfr_pkg::FRAME_LAST - FILL_W'(last_d_reg))
                                                 : (sfr_pkg::FRAME_FULL - FILL_W'(last_d_reg));
                    end
                end
            end
            sfr_pkg::ENG_EMIT: begin
                out_wr = out_free;
            end
        endcase

        drop_next = sfr_pkg::sat_add(drop_reg, drop_add);
    end

    always_comb begin
        out_res                      = '0;
        out_res.status               = status_reg;
        out_res.data.drop_total      = drop_reg;
        out_res.data.crc_error_total = crc_err_reg;
        if (status_reg == sfr_pkg::STATUS_ACCEPT) begin
            out_res.data.frame_seq       = seq_reg;
            out_res.data.pos_x           = payload_reg[15:0];
            out_res.data.pos_y           = payload_reg[31:16];
            out_res.data.heading         = payload_reg[47:32];
            out_res.data.button_bits     = payload_reg[63:48];
            out_res.data.remote_age      = payload_reg[95:64];
            out_res.data.event_code      = payload_reg[103:96];
            out_res.data.remote_sequence = payload_reg[111:104];
            out_res.data.safe_flag       = |payload_reg[119:112];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sfr_pkg::ENG_IDLE;
            status_reg  <= sfr_pkg::STATUS_NONE;
            head_reg    <= '0;
            fill_reg    <= '0;
            held_d_reg  <= 1'b0;
            drop_reg    <= '0;
            crc_err_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            held_d_reg  <= held_d_next;
            drop_reg    <= drop_next;
            crc_err_reg <= crc_err_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg  <= scan_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        crc_reg       <= crc_next;
        crc_rx_reg    <= crc_rx_next;
        hdr_ok_reg    <= hdr_ok_next;
        prev_d_reg    <= prev_d_next;
        found_reg     <= found_next;
        found_pos_reg <= found_pos_next;
        last_d_reg    <= last_d_next;
        seq_reg       <= seq_next;
        payload_reg   <= payload_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[mem_waddr] <= q_in.entry.rx_byte;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/sfr_out.sv
// result register: holds one result request until the sink takes it
// depends on sfr_pkg
`default_nettype none

module sfr_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr,
    input  sfr_pkg::result_t              res,
    output logic                          free,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // frame_seq, pos_x, pos_y, heading, button_bits, remote_age, event_code,
    // remote_sequence, safe_flag, drop_total, crc_error_total, zero pad
    output logic [sfr_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [sfr_pkg::TUSER_W-1:0]   m_axis_tuser  // status
);

    logic             valid_reg, valid_next;
    sfr_pkg::result_t res_reg;

    assign free          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.data;
    assign m_axis_tuser  = res_reg.status;

    always_comb begin
        valid_next = valid_reg;
        if (wr) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> sv/serial_frame_receiver_crc16.sv
// a result is registered for every byte taken from the input queue; a byte that completes
// a 24-byte window first takes one read pass through the window memory port
// the engine takes no new byte until the result of the last one is written; a 4-entry input
// queue keeps taking bytes meanwhile
// reset: aresetn synchronous active low clears queue, window fill, counters and output
// valid; window memory contents are not cleared
`default_nettype none
`include "serial_frame_receiver_crc16_assert.svh"

module serial_frame_receiver_crc16 #(
    parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // frame_seq, pos_x, pos_y, heading, button_bits, remote_age, event_code,
    // remote_sequence, safe_flag, drop_total, crc_error_total, zero pad
    output logic [sfr_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic [sfr_pkg::TUSER_W-1:0]     m_axis_tuser    // status
);

    sfr_pkg::queue_out_t           q_out;
    sfr_pkg::result_t              out_res;
    logic                          eng_pop;
    logic                          out_wr;
    logic                          out_free;
    logic [sfr_pkg::FILL_W-1:0]    fill_level;

    sfr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_pop         (eng_pop),
        .q_out         (q_out)
    );

    sfr_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_in       (q_out),
        .q_pop      (eng_pop),
        .out_free   (out_free),
        .out_wr     (out_wr),
        .out_res    (out_res),
        .fill_level (fill_level)
    );

    sfr_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wr            (out_wr),
        .res           (out_res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `SFR_ASSERT_SAME(a_pop_has_data, aclk, aresetn, eng_pop, q_out.valid, "pop from empty queue")
    `SFR_ASSERT_NEXT(a_pop_spaced, aclk, aresetn, eng_pop, !eng_pop, "back-to-back pops")
    `SFR_ASSERT_SAME(a_wr_has_room, aclk, aresetn, out_wr, out_free, "result written over pending result")
    `SFR_ASSERT_SAME(a_accept_empties, aclk, aresetn, out_wr && (out_res.status == sfr_pkg::STATUS_ACCEPT), fill_level == '0, "window not empty after accepted frame")

endmodule

`default_nettype wire

>>> test/tb_serial_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// self-checking bench for serial_frame_receiver_crc16: drives byte streams of framed packets,
// damaged packets and line noise, and predicts every report, from its own frame decoder or a typed row
// depends on sfr_pkg and the receiver top level

module tb_serial_frame_receiver_crc16;
    import sfr_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [127:0] DEMO_PAYLOAD = 128'hFF01FF00_FFFFFFFF_0000FFFF_7FFF8000;

    typedef enum logic [1:0] {
        ROW_PLAIN,
        ROW_CRC_LO,
        ROW_CRC_HI
    } row_kind_t;

    typedef enum logic [2:0] {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_HDR,
        FRAME_CUT,
        LINE_NOISE
    } frame_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  value;
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;

    logic [7:0]  held_bytes[$];
    logic [31:0] drop_tally     = '0;
    logic [31:0] crc_fail_tally = '0;
    result_t     awaited_reports[$];

    int unsigned src_gap_pct  = 0;
    int unsigned sink_gap_pct = 0;
    int unsigned sent_total   = 0;
    int unsigned hold_asked   = 0;
    int unsigned hold_done    = 0;
    int unsigned hold_left    = 0;
    int unsigned fault_count  = 0;
    int unsigned quiet_cycles = 0;

    serial_frame_receiver_crc16 u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] crc_of(input logic [7:0] src[$], input int from,
                                           input int cnt);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = from; i < from + cnt; i++) begin
            c = c ^ {src[i], 8'h00};
            for (int k = 0; k < 8; k++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_bump(input logic [31:0] base, input int n);
        logic [32:0] s;
        s = {1'b0, base} + 33'(n);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void drop_front(input int n);
        if (n >= held_bytes.size()) begin
            held_bytes.delete();
        end else begin
            repeat (n) void'(held_bytes.pop_front());
        end
    endfunction

    // frame decoder: one report per received byte
    function automatic result_t decode_rx_byte(input logic [7:0] value);
        result_t r;
        int      pos;
        int      keep;
        bit      done;
        r = '0;
        r.status = STATUS_NONE;
        if (held_bytes.size() >= FRAME_BYTES) begin
            drop_front(1);
            drop_tally = sat_bump(drop_tally, 1);
        end
        held_bytes.push_back(value);
        done = 1'b0;
        while (!done) begin
            pos = held_bytes.size();
            for (int i = 0; i + 1 < held_bytes.size(); i++) begin
                if (pos == held_bytes.size() && held_bytes[i] == SYNC0 &&
                    held_bytes[i+1] == SYNC1) begin
                    pos = i;
                end
            end
            if (pos == held_bytes.size()) begin
                // no sync pair: with more than one byte held, flush all but a trailing sync0
                if (held_bytes.size() > 1) begin
                    keep = (held_bytes[held_bytes.size()-1] == SYNC0) ? 1 : 0;
                    drop_tally = sat_bump(drop_tally, held_bytes.size() - keep);
                    drop_front(held_bytes.size() - keep);
                end
                done = 1'b1;
            end else begin
                if (pos > 0) begin
                    drop_front(pos);
                    drop_tally = sat_bump(drop_tally, pos);
                end
                if (held_bytes.size() < FRAME_BYTES) begin
                    done = 1'b1;
                end else if (held_bytes[IDX_VERSION] != HDR_VERSION ||
                             held_bytes[IDX_TYPE] != HDR_TYPE ||
                             held_bytes[IDX_LEN] != HDR_LEN) begin
                    drop_front(1);
                    drop_tally = sat_bump(drop_tally, 1);
                end else if (crc_of(held_bytes, 0, CRC_SPAN) !=
                             {held_bytes[IDX_CRC_HI], held_bytes[IDX_CRC_LO]}) begin
                    crc_fail_tally = sat_bump(crc_fail_tally, 1);
                    r.status = STATUS_CRC_ERR;
                    drop_front(1);
                end else begin
                    r.status               = STATUS_ACCEPT;
                    r.data.frame_seq       = held_bytes[4];
                    r.data.pos_x           = {held_bytes[7], held_bytes[6]};
                    r.data.pos_y           = {held_bytes[9], held_bytes[8]};
                    r.data.heading         = {held_bytes[11], held_bytes[10]};
                    r.data.button_bits     = {held_bytes[13], held_bytes[12]};
                    r.data.remote_age      = {held_bytes[17], held_bytes[16],
                                              held_bytes[15], held_bytes[14]};
                    r.data.event_code      = held_bytes[18];
                    r.data.remote_sequence = held_bytes[19];
                    r.data.safe_flag       = (held_bytes[20] != 8'h00);
                    held_bytes.delete();
                end
            end
        end
        r.data.drop_total      = drop_tally;
        r.data.crc_error_total = crc_fail_tally;
        return r;
    endfunction

    function automatic result_t idle_result(input logic [31:0] drops);
        result_t r;
        r = '0;
        r.status = STATUS_NONE;
        r.data.drop_total = drops;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return SYNC0;
            1: return SYNC1;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] value, input bit typed,
                             input result_t typed_want);
        result_t predicted;
        while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = decode_rx_byte(value);
        awaited_reports.push_back(typed ? typed_want : predicted);
        sent_total++;
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        int          idx;
        int          len;
        if (kind == LINE_NOISE) begin
            repeat ($urandom_range(6, 1)) send_byte(pick_byte(), 1'b0, '0);
        end else begin
            fr.push_back(SYNC0);
            fr.push_back(SYNC1);
            fr.push_back(HDR_VERSION);
            fr.push_back(HDR_TYPE);
            fr.push_back(pick_byte());
            fr.push_back(HDR_LEN);
            repeat (16) fr.push_back(pick_byte());
            if ($urandom_range(1) == 0) fr[20] = 8'h00;
            if (kind == FRAME_BAD_HDR) begin
                case ($urandom_range(2))
                    0: idx = IDX_VERSION;
                    1: idx = IDX_TYPE;
                    default: idx = IDX_LEN;
                endcase
                fr[idx] = fr[idx] ^ 8'($urandom_range(255, 1));
            end
            crc = crc_of(fr, 0, CRC_SPAN);
            if (kind == FRAME_BAD_CRC) crc = crc ^ 16'($urandom_range(65535, 1));
            fr.push_back(crc[7:0]);
            fr.push_back(crc[15:8]);
            len = (kind == FRAME_CUT) ? $urandom_range(FRAME_BYTES - 1, 2) : FRAME_BYTES;
            for (int i = 0; i < len; i++) send_byte(fr[i], 1'b0, '0);
        end
    endtask

    task automatic send_random(input int unsigned n_bytes);
        int unsigned start;
        int unsigned roll;
        start = sent_total;
        while (sent_total - start < n_bytes) begin
            roll = $urandom_range(99);
            if (roll < 60)      send_frame(FRAME_GOOD);
            else if (roll < 72) send_frame(FRAME_BAD_CRC);
            else if (roll < 82) send_frame(FRAME_BAD_HDR);
            else if (roll < 90) send_frame(FRAME_CUT);
            else                send_frame(LINE_NOISE);
        end
    endtask

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endfunction

    // report side: check, then decide next cycle's ready
    always @(posedge aclk) begin
        result_t   want;
        out_data_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (awaited_reports.size() == 0) begin
                $error("report with none outstanding");
                fault_count++;
            end else begin
                want = awaited_reports.pop_front();
                cmp_field("status", 32'(want.status), 32'(m_axis_tuser));
                cmp_field("frame_seq", want.data.frame_seq, got.frame_seq);
                cmp_field("pos_x", want.data.pos_x, got.pos_x);
                cmp_field("pos_y", want.data.pos_y, got.pos_y);
                cmp_field("heading", want.data.heading, got.heading);
                cmp_field("button_bits", want.data.button_bits, got.button_bits);
                cmp_field("remote_age", want.data.remote_age, got.remote_age);
                cmp_field("event_code", want.data.event_code, got.event_code);
                cmp_field("remote_sequence", want.data.remote_sequence,
                          got.remote_sequence);
                cmp_field("safe_flag", want.data.safe_flag, got.safe_flag);
                cmp_field("drop_total", want.data.drop_total, got.drop_total);
                cmp_field("crc_error_total", want.data.crc_error_total,
                          got.crc_error_total);
            end
        end
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t    dir_rows[$];
        result_t     frame_want;
        logic [7:0]  demo_log[$];
        logic [15:0] demo_crc;
        logic [7:0]  b;

        // sync hunt around a single good frame with extreme payload values
        dir_rows.push_back('{ROW_PLAIN, 8'h00, 1'b1, idle_result(0)});
        dir_rows.push_back('{ROW_PLAIN, 8'hFF, 1'b1, idle_result(2)});
        dir_rows.push_back('{ROW_PLAIN, SYNC0, 1'b1, idle_result(2)});
        dir_rows.push_back('{ROW_PLAIN, SYNC0, 1'b1, idle_result(3)});
        dir_rows.push_back('{ROW_PLAIN, SYNC1, 1'b0, '0});
        dir_rows.push_back('{ROW_PLAIN, HDR_VERSION, 1'b0, '0});
        dir_rows.push_back('{ROW_PLAIN, HDR_TYPE, 1'b0, '0});
        dir_rows.push_back('{ROW_PLAIN, 8'h00, 1'b0, '0});
        dir_rows.push_back('{ROW_PLAIN, HDR_LEN, 1'b0, '0});
        for (int i = 0; i < 16; i++) begin
            dir_rows.push_back('{ROW_PLAIN, DEMO_PAYLOAD[8*i +: 8], 1'b0, '0});
        end
        dir_rows.push_back('{ROW_CRC_LO, 8'h00, 1'b0, '0});
        frame_want = idle_result(3);
        frame_want.status               = STATUS_ACCEPT;
        frame_want.data.frame_seq       = 8'h00;
        frame_want.data.pos_x           = 16'h8000;
        frame_want.data.pos_y           = 16'h7FFF;
        frame_want.data.heading         = 16'hFFFF;
        frame_want.data.button_bits     = 16'h0000;
        frame_want.data.remote_age      = 32'hFFFF_FFFF;
        frame_want.data.event_code      = 8'h00;
        frame_want.data.remote_sequence = 8'hFF;
        frame_want.data.safe_flag       = 1'b1;
        dir_rows.push_back('{ROW_CRC_HI, 8'h00, 1'b1, frame_want});

        src_gap_pct  = 6;
        sink_gap_pct = 53;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CRC_LO: begin
                    demo_crc = crc_of(demo_log, demo_log.size() - CRC_SPAN, CRC_SPAN);
                    b = demo_crc[7:0];
                end
                ROW_CRC_HI: b = demo_crc[15:8];
                default:    b = dir_rows[i].value;
            endcase
            demo_log.push_back(b);
            send_byte(b, dir_rows[i].typed, dir_rows[i].want);
        end
        send_random(240);

        // hold requests until every report is back
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_reports.size() != 0) @(posedge aclk);

        src_gap_pct  = 53;
        sink_gap_pct = 6;
        send_random(250);

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        hold_asked++;
        send_random(250);

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
